// ===== hw/rtl/set_assoc_writeback_lru_cache_defines.svh =====
`ifndef SET_ASSOC_WRITEBACK_LRU_CACHE_DEFINES_SVH
`define SET_ASSOC_WRITEBACK_LRU_CACHE_DEFINES_SVH

// property checked on every rising clock edge outside reset
`define SAWLC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never occur
`define SAWLC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/sawlc_pkg.sv =====
package sawlc_pkg;

  localparam int unsigned WAYS_DEF       = 4;
  localparam int unsigned SETS_DEF       = 256;
  localparam int unsigned LINE_BYTES_DEF = 32;
  localparam int unsigned QDEPTH         = 2;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_FILL  = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam logic [1:0] KIND_RDATA = 2'd0;
  localparam logic [1:0] KIND_WDONE = 2'd1;
  localparam logic [1:0] KIND_WB    = 2'd2;
  localparam logic [1:0] KIND_FREQ  = 2'd3;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_TAG,
    S_RDOUT,
    S_WB,
    S_FREQ,
    S_FILLMETA
  } state_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] address;
    logic [31:0] write_data;
    logic [31:0] fill_data;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] out_address;
    logic [31:0] out_data;
    logic        was_hit;
    logic        last;
  } res_t;

  typedef struct packed {
    logic valid;
    req_t req;
  } queue_t;

endpackage

// ===== hw/rtl/set_assoc_writeback_lru_cache.sv =====
// channel   | handshake          | payload
// request   | start / busy       | req_i
// result    | valid_o (strobe)   | res_o
// a read hit and a write hit each do one metadata ram read and one data ram access
// a clean miss asks for the fill from the tag state; a dirty one first writes back the line
// each fill word is written as it is popped; the last one adds a metadata update and a data access
// after reset busy stays high while the metadata ram is cleared set by set
// a two-entry request queue keeps taking requests while the back end works, until it is full
// results are strobed for one cycle and are never held off
`include "set_assoc_writeback_lru_cache_defines.svh"

module set_assoc_writeback_lru_cache
  import sawlc_pkg::*;
#(
  parameter int unsigned WAYS       = WAYS_DEF,
  parameter int unsigned SETS       = SETS_DEF,
  parameter int unsigned LINE_BYTES = LINE_BYTES_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic valid_o,
  output res_t res_o
);

  queue_t head;
  logic   pop, full, clearing;

  assign busy = full | clearing;

  sawlc_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (start && !busy),
    .req_i  (req_i),
    .pop_i  (pop),
    .head_o (head),
    .full_o (full)
  );

  sawlc_back #(
    .WAYS       (WAYS),
    .SETS       (SETS),
    .LINE_BYTES (LINE_BYTES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .pop_o      (pop),
    .clearing_o (clearing),
    .valid_o    (valid_o),
    .res_o      (res_o)
  );

  `SAWLC_ASSERT(a_wb_not_last, valid_o && res_o.kind == KIND_WB |-> !res_o.last, "wb last")
  `SAWLC_ASSERT(a_freq_last, valid_o && res_o.kind == KIND_FREQ |-> res_o.last, "freq not last")
  `SAWLC_NEVER(a_no_out_clear, valid_o && clearing, "result during clear")

endmodule

// ===== hw/rtl/sawlc_ram.sv =====
module sawlc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/sawlc_front.sv =====
module sawlc_front
  import sawlc_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  req_t   req_i,
  input  logic   pop_i,
  output queue_t head_o,
  output logic   full_o
);

  localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  req_t          mem_q [QDEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_pop;

  assign full_o      = (cnt_q == CW'(QDEPTH));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.req   = mem_q[rd_q];
  assign do_pop       = pop_i && head_o.valid;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= req_i;
    end
  end

endmodule

// ===== hw/rtl/sawlc_back.sv =====
module sawlc_back
  import sawlc_pkg::*;
#(
  parameter int unsigned WAYS       = WAYS_DEF,
  parameter int unsigned SETS       = SETS_DEF,
  parameter int unsigned LINE_BYTES = LINE_BYTES_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  queue_t head_i,
  output logic   pop_o,
  output logic   clearing_o,
  output logic   valid_o,
  output res_t   res_o
);

  localparam int unsigned OB    = $clog2(LINE_BYTES);
  localparam int unsigned IB    = $clog2(SETS);
  localparam int unsigned TAG_W = 32 - OB - IB;
  localparam int unsigned WPL   = LINE_BYTES / 4;
  localparam int unsigned WO_W  = $clog2(WPL);
  localparam int unsigned WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned AGE_W = WAY_W;
  localparam int unsigned MW    = WAYS * (TAG_W + AGE_W + 2);
  localparam int unsigned DAW   = IB + WAY_W + WO_W;
  localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(WAYS - 1);

  state_e state_q, state_d;

  req_t              cur_q, cur_d;
  logic [IB-1:0]     clr_q, clr_d;
  logic              pend_q, pend_d;
  logic              pwr_q, pwr_d;
  logic [31:0]       paddr_q, paddr_d;
  logic [31:0]       pword_q, pword_d;
  logic [WO_W-1:0]   fcnt_q, fcnt_d;
  logic [WAY_W-1:0]  vict_q, vict_d;
  logic [WO_W-1:0]   wbc_q, wbc_d;
  logic [31:0]       wbase_q, wbase_d;
  logic              hit_q, hit_d;
  logic [31:0]       raddr_q, raddr_d;
  logic              valid_q, valid_d;
  res_t              res_q, res_d;

  logic              meta_we;
  logic [IB-1:0]     meta_addr;
  logic [MW-1:0]     meta_wdata, meta_rdata;
  logic              data_we;
  logic [DAW-1:0]    data_addr;
  logic [31:0]       data_wdata, data_rdata;

  logic [WAYS-1:0]                  r_valid, r_dirty;
  logic [WAYS-1:0][AGE_W-1:0]       r_age;
  logic [WAYS-1:0][TAG_W-1:0]       r_tag;
  logic [WAYS-1:0]                  n_valid, n_dirty;
  logic [WAYS-1:0][AGE_W-1:0]       n_age;
  logic [WAYS-1:0][TAG_W-1:0]       n_tag;

  logic [IB-1:0]     c_set, p_set, h_set;
  logic [TAG_W-1:0]  c_tag, p_tag;
  logic [WO_W-1:0]   c_wo, p_wo;
  logic              hit;
  logic [WAY_W-1:0]  hit_way, vict, touch_way;

  sawlc_ram #(.WIDTH(MW), .DEPTH(SETS)) u_meta (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .addr_i  (meta_addr),
    .wdata_i (meta_wdata),
    .rdata_o (meta_rdata)
  );

  sawlc_ram #(.WIDTH(32), .DEPTH(2 ** DAW)) u_data (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .addr_i  (data_addr),
    .wdata_i (data_wdata),
    .rdata_o (data_rdata)
  );

  assign {r_tag, r_age, r_dirty, r_valid} = meta_rdata;

  assign c_set = cur_q.address[OB +: IB];
  assign c_tag = cur_q.address[31 -: TAG_W];
  assign c_wo  = cur_q.address[2 +: WO_W];
  assign p_set = paddr_q[OB +: IB];
  assign p_tag = paddr_q[31 -: TAG_W];
  assign p_wo  = paddr_q[2 +: WO_W];
  assign h_set = head_i.req.address[OB +: IB];

  // tag compare and victim choice
  always_comb begin
    logic             inv_found;
    logic [AGE_W-1:0] best;
    hit       = 1'b0;
    hit_way   = '0;
    inv_found = 1'b0;
    vict      = '0;
    best      = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit && r_valid[w] && (r_tag[w] == c_tag)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!inv_found && !r_valid[w]) begin
        inv_found = 1'b1;
        vict      = WAY_W'(w);
      end
    end
    if (!inv_found) begin
      for (int w = 0; w < WAYS; w++) begin
        if (r_age[w] > best) begin
          best = r_age[w];
          vict = WAY_W'(w);
        end
      end
    end
  end

  assign touch_way = (state_q == S_FILLMETA) ? vict_q : hit_way;

  // age update and row rewrite
  always_comb begin
    n_valid = r_valid;
    n_dirty = r_dirty;
    n_tag   = r_tag;
    for (int w = 0; w < WAYS; w++) begin
      if (WAY_W'(w) == touch_way) begin
        n_age[w] = '0;
      end else if (r_age[w] < AGE_MAX) begin
        n_age[w] = r_age[w] + 1'b1;
      end else begin
        n_age[w] = r_age[w];
      end
    end
    if (state_q == S_FILLMETA) begin
      n_valid[vict_q] = 1'b1;
      n_dirty[vict_q] = pwr_q;
      n_tag[vict_q]   = p_tag;
    end else if (hit) begin
      n_dirty[hit_way] = r_dirty[hit_way] | (cur_q.opcode == OP_WRITE);
    end else begin
      n_valid[vict] = 1'b0;
      n_dirty[vict] = 1'b0;
      n_age         = r_age;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == IB'(SETS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (head_i.valid) begin
          if (head_i.req.opcode == OP_FILL) begin
            if (pend_q && fcnt_q == WO_W'(WPL - 1)) state_d = S_FILLMETA;
          end else if (head_i.req.opcode != OP_NONE && !pend_q) begin
            state_d = S_TAG;
          end
        end
      end
      S_TAG: begin
        if (hit) begin
          state_d = (cur_q.opcode == OP_WRITE) ? S_IDLE : S_RDOUT;
        end else begin
          state_d = (r_valid[vict] && r_dirty[vict]) ? S_WB : S_IDLE;
        end
      end
      S_WB: begin
        if (wbc_q == WO_W'(WPL - 1)) state_d = S_FREQ;
      end
      S_FREQ:     state_d = S_IDLE;
      S_RDOUT:    state_d = S_IDLE;
      S_FILLMETA: state_d = pwr_q ? S_IDLE : S_RDOUT;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    pop_o      = 1'b0;
    meta_we    = 1'b0;
    meta_addr  = c_set;
    meta_wdata = {n_tag, n_age, n_dirty, n_valid};
    data_we    = 1'b0;
    data_addr  = {c_set, hit_way, c_wo};
    data_wdata = cur_q.write_data;
    cur_d      = cur_q;
    clr_d      = clr_q;
    pend_d     = pend_q;
    pwr_d      = pwr_q;
    paddr_d    = paddr_q;
    pword_d    = pword_q;
    fcnt_d     = fcnt_q;
    vict_d     = vict_q;
    wbc_d      = wbc_q;
    wbase_d    = wbase_q;
    hit_d      = hit_q;
    raddr_d    = raddr_q;
    valid_d    = 1'b0;
    res_d      = res_q;
    case (state_q)
      S_CLEAR: begin
        meta_we    = 1'b1;
        meta_addr  = clr_q;
        meta_wdata = '0;
        clr_d      = clr_q + 1'b1;
      end
      S_IDLE: begin
        if (head_i.valid) begin
          pop_o     = 1'b1;
          cur_d     = head_i.req;
          meta_addr = h_set;
          if (head_i.req.opcode == OP_FILL && pend_q) begin
            data_we    = 1'b1;
            data_addr  = {p_set, vict_q, fcnt_q};
            data_wdata = head_i.req.fill_data;
            if (fcnt_q == WO_W'(WPL - 1)) begin
              fcnt_d    = '0;
              meta_addr = p_set;
            end else begin
              fcnt_d = fcnt_q + 1'b1;
            end
          end
        end
      end
      S_TAG: begin
        meta_we = 1'b1;
        if (hit) begin
          if (cur_q.opcode == OP_WRITE) begin
            data_we = 1'b1;
            valid_d = 1'b1;
            res_d   = '{KIND_WDONE, {cur_q.address[31:2], 2'b00}, 32'd0, 1'b1, 1'b1};
          end else begin
            hit_d   = 1'b1;
            raddr_d = {cur_q.address[31:2], 2'b00};
          end
        end else begin
          vict_d    = vict;
          pend_d    = 1'b1;
          pwr_d     = (cur_q.opcode == OP_WRITE);
          paddr_d   = cur_q.address;
          pword_d   = (cur_q.opcode == OP_WRITE) ? cur_q.write_data : 32'd0;
          fcnt_d    = '0;
          wbc_d     = '0;
          wbase_d   = {r_tag[vict], c_set, OB'(0)};
          data_addr = {c_set, vict, WO_W'(0)};
          if (!(r_valid[vict] && r_dirty[vict])) begin
            valid_d = 1'b1;
            res_d   = '{KIND_FREQ, {cur_q.address[31:OB], OB'(0)}, 32'd0, 1'b0, 1'b1};
          end
        end
      end
      S_WB: begin
        valid_d   = 1'b1;
        res_d     = '{KIND_WB, wbase_q | {{(30 - WO_W){1'b0}}, wbc_q, 2'b00},
                      data_rdata, 1'b0, 1'b0};
        wbc_d     = wbc_q + 1'b1;
        data_addr = {p_set, vict_q, wbc_d};
      end
      S_FREQ: begin
        valid_d = 1'b1;
        res_d   = '{KIND_FREQ, {paddr_q[31:OB], OB'(0)}, 32'd0, 1'b0, 1'b1};
      end
      S_RDOUT: begin
        valid_d = 1'b1;
        res_d   = '{KIND_RDATA, raddr_q, data_rdata, hit_q, 1'b1};
      end
      S_FILLMETA: begin
        meta_we    = 1'b1;
        meta_addr  = p_set;
        pend_d     = 1'b0;
        data_addr  = {p_set, vict_q, p_wo};
        data_wdata = pword_q;
        if (pwr_q) begin
          data_we = 1'b1;
          valid_d = 1'b1;
          res_d   = '{KIND_WDONE, {paddr_q[31:2], 2'b00}, 32'd0, 1'b0, 1'b1};
        end else begin
          hit_d   = 1'b0;
          raddr_d = {paddr_q[31:2], 2'b00};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      pend_q  <= 1'b0;
      pwr_q   <= 1'b0;
      paddr_q <= '0;
      pword_q <= '0;
      fcnt_q  <= '0;
      vict_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      pend_q  <= pend_d;
      pwr_q   <= pwr_d;
      paddr_q <= paddr_d;
      pword_q <= pword_d;
      fcnt_q  <= fcnt_d;
      vict_q  <= vict_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    wbc_q   <= wbc_d;
    wbase_q <= wbase_d;
    hit_q   <= hit_d;
    raddr_q <= raddr_d;
    res_q   <= res_d;
  end

  assign clearing_o = (state_q == S_CLEAR);
  assign valid_o    = valid_q;
  assign res_o      = res_q;

endmodule
